// ===== rtl/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the keyed slot table
// Request and response beats, request and status codes, sequencer states and
// the compare unit's result.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int CNT_W = 6;

  localparam logic [KEY_W-1:0] INVALID_KEY = '1;

  typedef enum logic [1:0] {
    REQ_ADD,
    REQ_FIND,
    REQ_REMOVE,
    REQ_SORT
  } req_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_FULL,
    ST_BAD_KEY
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_SORT_HLD,
    S_SORT_CMP,
    S_SORT_PUT
  } state_e;

  typedef struct packed {
    req_e             req_type;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload_in;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic             found;
    logic [PAY_W-1:0] payload_out;
    logic [CNT_W-1:0] entry_count;
    logic             is_sorted;
  } rsp_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/kst_mem.sv =====
// ----------------------------------------------------------------------------
// kst_mem: entry storage
// Key and payload arrays, one write port and one read port, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_mem
  import kst_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int PW    = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [KEY_W-1:0]         wkey_i,
  input  wire logic [PW-1:0]            wpay_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [KEY_W-1:0]         rkey_o,
  output      logic [PW-1:0]            rpay_o
);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [PW-1:0]    pay_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      pay_mem[waddr_i] <= wpay_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rpay_o <= pay_mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/kst_cmp.sv =====
// ----------------------------------------------------------------------------
// kst_cmp: shared key compare unit
// Equality for the search walk, unsigned greater-than for the sort.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_cmp
  import kst_pkg::*;
(
  input  wire logic [KEY_W-1:0] a_i,
  input  wire logic [KEY_W-1:0] b_i,
  output      cmp_t             res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

`default_nettype wire

// ===== rtl/keyed_slot_table.sv =====
// Add, a refused request, and a search of an empty table give the result strobe
//   in the cycle after the accept; find and remove walk the table entry by entry.
// Sort is an insertion sort through the single memory port pair: each entry is
//   held, larger neighbours move up one place each, and the held entry is placed.
// One request at a time; busy is high while the sequencer walks the table.
// Reset clears the entry count and sorted flag at once; storage is not cleared.
// ----------------------------------------------------------------------------
// keyed_slot_table: bounded key/payload table with search, remove and sort
// A small sequencer drives one memory port pair and one shared key compare.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_slot_table
  import kst_pkg::*;
#(
  parameter int TABLE_DEPTH  = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output      logic busy,
  input  wire req_t req_i,
  output      rsp_t rsp_o,
  output      logic done_o
);

  // Address and count widths; the count must hold TABLE_DEPTH itself.
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  // Stored payload width: the beat carries at most PAY_W bits.
  localparam int SW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

  localparam logic [CW-1:0] DEPTH_C  = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [AW-1:0] ADDR_ONE = AW'(1);

  // Sequencer state
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            sorted_q, sorted_d;
  logic            is_rm_q, is_rm_d;
  // Operand key: request key during a search, held key during a sort pass.
  logic [KEY_W-1:0] op_key_q, op_key_d;
  logic [SW-1:0]    hold_pay_q, hold_pay_d;
  // Read pointer and the index of the beat now in the read register.
  logic [CW-1:0]   rd_idx_q, rd_idx_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CW-1:0]   chk_idx_q, chk_idx_d;
  // Insertion sort: outer entry and hole position.
  logic [CW-1:0]   i_q, i_d;
  logic [CW-1:0]   j_q, j_d;

  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  // Memory port
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wkey;
  logic [SW-1:0]    mem_wpay;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rkey;
  logic [SW-1:0]    mem_rpay;

  cmp_t            cmp;

  logic            accept;
  logic            outer_next;
  status_e         res_status;
  logic            res_found;
  logic [PAY_W-1:0] res_pay;

  logic [CW-1:0]   cnt_p1, last_idx, i_p1, i_m1, j_m1, j_m2, chk_p1, chk_m1, rd_p1;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign cnt_p1   = cnt_q + 1'b1;
  assign last_idx = cnt_q - 1'b1;
  assign i_p1     = i_q + 1'b1;
  assign i_m1     = i_q - 1'b1;
  assign j_m1     = j_q - 1'b1;
  assign j_m2     = j_q - 2'd2;
  assign chk_p1   = chk_idx_q + 1'b1;
  assign chk_m1   = chk_idx_q - 1'b1;
  assign rd_p1    = rd_idx_q + 1'b1;

  kst_mem #(
    .DEPTH (TABLE_DEPTH),
    .PW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wpay_i  (mem_wpay),
    .raddr_i (mem_raddr),
    .rkey_o  (mem_rkey),
    .rpay_o  (mem_rpay)
  );

  // Single compare unit shared by the search walk and the sort.
  kst_cmp u_cmp (
    .a_i   (mem_rkey),
    .b_i   (op_key_q),
    .res_o (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      sorted_q  <= 1'b0;
      chk_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      sorted_q  <= sorted_d;
      chk_vld_q <= chk_vld_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_rm_q    <= is_rm_d;
    op_key_q   <= op_key_d;
    hold_pay_q <= hold_pay_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    i_q        <= i_d;
    j_q        <= j_d;
    rsp_q      <= rsp_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sorted_d   = sorted_q;
    is_rm_d    = is_rm_q;
    op_key_d   = op_key_q;
    hold_pay_d = hold_pay_q;
    rd_idx_d   = rd_idx_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    i_d        = i_q;
    j_d        = j_q;
    done_d     = 1'b0;
    outer_next = 1'b0;
    res_status = ST_OK;
    res_found  = 1'b0;
    res_pay    = '0;
    mem_we     = 1'b0;
    mem_waddr  = j_q[AW-1:0];
    mem_wkey   = op_key_q;
    mem_wpay   = hold_pay_q;
    mem_raddr  = rd_idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        // Prefetch entry 0 for a search, entry 1 for a sort.
        mem_raddr = (req_i.req_type == REQ_SORT) ? ADDR_ONE : '0;
        if (accept) begin
          op_key_d = req_i.key;
          is_rm_d  = (req_i.req_type == REQ_REMOVE);
          case (req_i.req_type)
            REQ_ADD: begin
              done_d = 1'b1;
              if (cnt_q == DEPTH_C) begin
                res_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wkey  = req_i.key;
                mem_wpay  = req_i.payload_in[SW-1:0];
                cnt_d     = cnt_p1;
                sorted_d  = 1'b0;
              end
            end
            REQ_FIND, REQ_REMOVE: begin
              if (req_i.key == INVALID_KEY) begin
                done_d     = 1'b1;
                res_status = ST_BAD_KEY;
              end else if (cnt_q == '0) begin
                done_d     = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                state_d   = S_SCAN;
                chk_vld_d = 1'b1;
                chk_idx_d = '0;
                rd_idx_d  = CNT_ONE;
              end
            end
            default: begin
              sorted_d = 1'b1;
              if (cnt_q <= CNT_ONE) begin
                done_d = 1'b1;
              end else begin
                i_d     = CNT_ONE;
                state_d = S_SORT_HLD;
              end
            end
          endcase
        end
      end

      // One entry read per cycle; compare the beat in the read register.
      S_SCAN: begin
        if (rd_idx_q < cnt_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          rd_idx_d  = rd_p1;
        end
        if (chk_vld_q) begin
          if (cmp.eq) begin
            if (!is_rm_q) begin
              done_d    = 1'b1;
              res_found = 1'b1;
              res_pay   = PAY_W'(mem_rpay);
              state_d   = S_IDLE;
            end else if (chk_idx_q == last_idx) begin
              // last entry: nothing to move
              done_d    = 1'b1;
              res_found = 1'b1;
              cnt_d     = last_idx;
              state_d   = S_IDLE;
            end else begin
              mem_raddr = chk_p1[AW-1:0];
              chk_vld_d = 1'b1;
              chk_idx_d = chk_p1;
              rd_idx_d  = chk_p1 + 1'b1;
              state_d   = S_SHIFT;
            end
          end else if (chk_idx_q == last_idx) begin
            done_d     = 1'b1;
            res_status = ST_NOT_FOUND;
            state_d    = S_IDLE;
          end
        end
      end

      // Close the gap: entry k moves to k-1, one per cycle.
      S_SHIFT: begin
        if (rd_idx_q < cnt_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = rd_idx_q;
          rd_idx_d  = rd_p1;
        end
        if (chk_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = chk_m1[AW-1:0];
          mem_wkey  = mem_rkey;
          mem_wpay  = mem_rpay;
          if (chk_idx_q == last_idx) begin
            done_d    = 1'b1;
            res_found = 1'b1;
            cnt_d     = last_idx;
            state_d   = S_IDLE;
          end
        end
      end

      S_SORT_HLD: begin
        op_key_d   = mem_rkey;
        hold_pay_d = mem_rpay;
        j_d        = i_q;
        mem_raddr  = i_m1[AW-1:0];
        state_d    = S_SORT_CMP;
      end

      S_SORT_CMP: begin
        mem_we = 1'b1;
        if (cmp.gt) begin
          // larger neighbor moves up into the hole
          mem_wkey = mem_rkey;
          mem_wpay = mem_rpay;
          j_d      = j_m1;
          if (j_q == CNT_ONE) begin
            state_d = S_SORT_PUT;
          end else begin
            mem_raddr = j_m2[AW-1:0];
          end
        end else begin
          outer_next = 1'b1;
        end
      end

      S_SORT_PUT: begin
        mem_we     = 1'b1;
        outer_next = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Held entry placed; move on to the next outer entry or finish.
    if (outer_next) begin
      if (i_q == last_idx) begin
        done_d  = 1'b1;
        state_d = S_IDLE;
      end else begin
        i_d       = i_p1;
        mem_raddr = i_p1[AW-1:0];
        state_d   = S_SORT_HLD;
      end
    end

    rsp_d.status      = res_status;
    rsp_d.found       = res_found;
    rsp_d.payload_out = res_pay;
    rsp_d.entry_count = CNT_W'(cnt_d);
    rsp_d.is_sorted   = sorted_d;
  end

endmodule

`default_nettype wire

// ===== rtl/kst_checker.sv =====
// ----------------------------------------------------------------------------
// kst_props: port-level checks of the keyed slot table
// Watches the command and result ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_props
  import kst_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_i,
  input wire req_t req_i,
  input wire rsp_t rsp_i,
  input wire logic done_i
);

  // A result strobe always lands with the sequencer back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result strobe while busy");

  // Every accepted beat either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> (done_i || busy_i))
    else $error("accepted request neither answered nor in progress");

  // Add never walks the table.
  a_add_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && req_i.req_type == REQ_ADD) |=> done_i)
    else $error("add did not answer in one cycle");

  // A match is always reported as ok.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && rsp_i.found) |-> (rsp_i.status == ST_OK))
    else $error("match reported with error status");

  // Payload only comes back with a match.
  a_payload_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && rsp_i.payload_out != '0) |-> rsp_i.found)
    else $error("payload without match");

endmodule

bind keyed_slot_table kst_props u_kst_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start),
  .busy_i  (busy),
  .req_i   (req_i),
  .rsp_i   (rsp_o),
  .done_i  (done_o)
);

`default_nettype wire
